// ===== hdl/kpf2d_pkg.sv =====
// Package for the 2-D position Kalman filter: widths, codes, sequencer types and helpers.
package kpf2d_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int SAT_W     = 6;
  localparam int CFG_AW    = 3;
  localparam int IN_W      = ((2 * DATA_W + SAT_W + 7) / 8) * 8;
  localparam int OUT_W     = 2 * DATA_W;

  // multiplier operands carry one extra bit so that a negated minimum fits
  localparam int OP_W   = DATA_W + 1;
  localparam int PROD_W = 2 * OP_W;
  // two scaled products plus one 32-bit value
  localparam int ACC_W  = 2 * DATA_W + 1 - FRAC_BITS;
  localparam int NUM_W  = ACC_W + FRAC_BITS;
  localparam int QUO_W  = DATA_W + 1;
  localparam int CNT_W  = $clog2(QUO_W);

  localparam logic [CFG_AW-1:0] REG_PROC_VAR_X  = CFG_AW'(0);
  localparam logic [CFG_AW-1:0] REG_PROC_VAR_Y  = CFG_AW'(1);
  localparam logic [CFG_AW-1:0] REG_MEAS_VAR_X  = CFG_AW'(2);
  localparam logic [CFG_AW-1:0] REG_MEAS_VAR_Y  = CFG_AW'(3);
  localparam logic [CFG_AW-1:0] REG_MIN_SATS    = CFG_AW'(4);

  typedef logic signed [DATA_W-1:0] q_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [OP_W-1:0]   op_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  localparam q_t Q_MAX = {1'b0, {(DATA_W - 1){1'b1}}};
  localparam q_t Q_MIN = {1'b1, {(DATA_W - 1){1'b0}}};
  localparam q_t Q_ONE = q_t'(64'd1 << FRAC_BITS);
  localparam logic [DATA_W-1:0] VAR_RESET = DATA_W'(64'd1 << FRAC_BITS);
  localparam logic [SAT_W-1:0]  MIN_SATS_RESET = SAT_W'(6);
  localparam logic [QUO_W-1:0]  QUO_LIM = QUO_W'(64'd1 << (DATA_W - 1));
  localparam longint RND_HALF = longint'(64'd1 << (FRAC_BITS - 1));

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_SUMS,
    ST_MUL,
    ST_ACC,
    ST_DIV_INIT,
    ST_DIV,
    ST_DIV_END,
    ST_MCONV,
    ST_DONE
  } state_t;

  // one group = two scaled products summed into the accumulator
  typedef enum logic [3:0] {
    G_DET,
    G_K00,
    G_K01,
    G_K10,
    G_K11,
    G_EST_X,
    G_EST_Y,
    G_P00,
    G_P01,
    G_P10,
    G_P11
  } grp_t;

  function automatic q_t sat_q(input acc_t v);
    if (v > acc_t'(Q_MAX)) begin
      return Q_MAX;
    end else if (v < acc_t'(Q_MIN)) begin
      return Q_MIN;
    end
    return q_t'(v);
  endfunction

  // scale a product down by the fraction bits, rounding half away from zero
  function automatic acc_t qround(input prod_t p);
    prod_t bias;
    prod_t t;
    bias = p[PROD_W-1] ? prod_t'(RND_HALF - 1) : prod_t'(RND_HALF);
    t = p + bias;
    return acc_t'(t >>> FRAC_BITS);
  endfunction

endpackage

// ===== hdl/kalman_position_filter_2d_unit.sv =====
// Top level of the 2-D random-walk Kalman position filter with one shared multiplier.
// Each fix on the input stream yields exactly one word on the output stream: the
// current estimate and a flag that tells whether the fix was applied. A fix with fewer
// satellites than min_satellites skips the filter and is answered with the estimate unchanged.
// A fix that is applied runs 22 scaled products through the single 33x33 multiplier
// and four gain divisions through a radix-2 divider (a gain whose quotient would not
// fit skips the divider loop). A singular innovation covariance ends the work after
// the determinant, with nothing committed. The input is ready only while no fix is
// in work; the output register lets the next fix enter while the last result still
// waits. Configuration is to be written only when idle; the block does not enforce it.
module kalman_position_filter_2d_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [kpf2d_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [kpf2d_pkg::DATA_W-1:0]    cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [kpf2d_pkg::IN_W-1:0]      in_tdata,   // pos_x, pos_y, sat_count, zero pad
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [kpf2d_pkg::OUT_W-1:0]     out_tdata,  // est_x, est_y
  output logic                            out_tuser   // updated
);
  import kpf2d_pkg::*;

  state_t state_r, state_nxt;
  grp_t   grp_r, grp_nxt;
  logic   half_r, half_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [DATA_W-1:0] pvx_r, pvy_r, mvx_r, mvy_r;
  logic [SAT_W-1:0]  min_sat_r;

  q_t est_r [2];
  q_t est_nxt [2];
  q_t cov_r [4];
  q_t cov_nxt [4];
  q_t p_r [4];
  q_t p_nxt [4];
  q_t k_r [4];
  q_t k_nxt [4];
  q_t inn_r [2];
  q_t inn_nxt [2];
  q_t s0_r, s0_nxt, s3_r, s3_nxt;
  q_t zx_r, zx_nxt, zy_r, zy_nxt;

  prod_t prod_r, prod_nxt;
  acc_t  acc_r, acc_nxt;
  acc_t  acc_sum;
  logic [ACC_W-1:0] ud_r, ud_nxt;
  logic [ACC_W-1:0] rem_r, rem_nxt;
  logic [ACC_W-1:0] trial;
  logic [ACC_W-1:0] num_abs;
  logic [NUM_W-1:0] num_w;
  logic [NUM_W-1:0] num_hi;
  logic [QUO_W-1:0] dvd_r, dvd_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic det_neg_r, det_neg_nxt;
  logic k_neg_r, k_neg_nxt;
  q_t   k_val;
  logic upd_r, upd_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]  out_data_r, out_data_nxt;
  logic              out_user_r, out_user_nxt;

  op_t op_a, op_b;
  op_t neg_p1, neg_p2;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign in_tready  = (state_r == ST_IDLE);

  // operand select for the shared multiplier
  always_comb begin
    neg_p1 = -op_t'(p_r[1]);
    neg_p2 = -op_t'(p_r[2]);
    unique case (grp_r)
      G_DET: begin
        op_a = half_r ? op_t'(p_r[1]) : op_t'(s0_r);
        op_b = half_r ? neg_p2 : op_t'(s3_r);
      end
      G_K00: begin
        op_a = half_r ? op_t'(p_r[1]) : op_t'(p_r[0]);
        op_b = half_r ? neg_p2 : op_t'(s3_r);
      end
      G_K01: begin
        op_a = half_r ? op_t'(p_r[1]) : op_t'(p_r[0]);
        op_b = half_r ? op_t'(s0_r) : neg_p1;
      end
      G_K10: begin
        op_a = half_r ? op_t'(p_r[3]) : op_t'(p_r[2]);
        op_b = half_r ? neg_p2 : op_t'(s3_r);
      end
      G_K11: begin
        op_a = half_r ? op_t'(p_r[3]) : op_t'(p_r[2]);
        op_b = half_r ? op_t'(s0_r) : neg_p1;
      end
      G_EST_X: begin
        op_a = half_r ? op_t'(k_r[1]) : op_t'(k_r[0]);
        op_b = half_r ? op_t'(inn_r[1]) : op_t'(inn_r[0]);
      end
      G_EST_Y: begin
        op_a = half_r ? op_t'(k_r[3]) : op_t'(k_r[2]);
        op_b = half_r ? op_t'(inn_r[1]) : op_t'(inn_r[0]);
      end
      G_P00: begin
        op_a = half_r ? op_t'(k_r[1]) : op_t'(k_r[0]);
        op_b = half_r ? op_t'(p_r[2]) : op_t'(p_r[0]);
      end
      G_P01: begin
        op_a = half_r ? op_t'(k_r[1]) : op_t'(k_r[0]);
        op_b = half_r ? op_t'(p_r[3]) : op_t'(p_r[1]);
      end
      G_P10: begin
        op_a = half_r ? op_t'(k_r[3]) : op_t'(k_r[2]);
        op_b = half_r ? op_t'(p_r[2]) : op_t'(p_r[0]);
      end
      G_P11: begin
        op_a = half_r ? op_t'(k_r[3]) : op_t'(k_r[2]);
        op_b = half_r ? op_t'(p_r[3]) : op_t'(p_r[1]);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    grp_nxt       = grp_r;
    half_nxt      = half_r;
    cnt_nxt       = cnt_r;
    est_nxt       = est_r;
    cov_nxt       = cov_r;
    p_nxt         = p_r;
    k_nxt         = k_r;
    inn_nxt       = inn_r;
    s0_nxt        = s0_r;
    s3_nxt        = s3_r;
    zx_nxt        = zx_r;
    zy_nxt        = zy_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    ud_nxt        = ud_r;
    rem_nxt       = rem_r;
    dvd_nxt       = dvd_r;
    quo_nxt       = quo_r;
    det_neg_nxt   = det_neg_r;
    k_neg_nxt     = k_neg_r;
    upd_nxt       = upd_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;

    acc_sum = acc_r + qround(prod_r);
    num_abs = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
    num_w   = {num_abs, {FRAC_BITS{1'b0}}};
    num_hi  = num_w >> QUO_W;
    trial   = {rem_r[ACC_W-2:0], dvd_r[QUO_W-1]};
    if (k_neg_r) begin
      k_val = (quo_r > QUO_LIM) ? Q_MIN : q_t'(-quo_r);
    end else begin
      k_val = (quo_r >= QUO_LIM) ? Q_MAX : q_t'(quo_r);
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          zx_nxt = q_t'(in_tdata[DATA_W-1:0]);
          zy_nxt = q_t'(in_tdata[2*DATA_W-1:DATA_W]);
          if (in_tdata[2*DATA_W +: SAT_W] >= min_sat_r) begin
            state_nxt = ST_PREP;
          end else begin
            upd_nxt   = 1'b0;
            state_nxt = ST_DONE;
          end
        end
      end
      ST_PREP: begin
        p_nxt[0]   = sat_q(acc_t'(cov_r[0]) + acc_t'(pvx_r));
        p_nxt[1]   = cov_r[1];
        p_nxt[2]   = cov_r[2];
        p_nxt[3]   = sat_q(acc_t'(cov_r[3]) + acc_t'(pvy_r));
        inn_nxt[0] = sat_q(acc_t'(zx_r) - acc_t'(est_r[0]));
        inn_nxt[1] = sat_q(acc_t'(zy_r) - acc_t'(est_r[1]));
        state_nxt  = ST_SUMS;
      end
      ST_SUMS: begin
        s0_nxt    = sat_q(acc_t'(mvx_r) + acc_t'(p_r[0]));
        s3_nxt    = sat_q(acc_t'(mvy_r) + acc_t'(p_r[3]));
        grp_nxt   = G_DET;
        half_nxt  = 1'b0;
        acc_nxt   = '0;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        prod_nxt  = op_a * op_b;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        acc_nxt = acc_sum;
        if (!half_r) begin
          half_nxt  = 1'b1;
          state_nxt = ST_MUL;
        end else begin
          half_nxt = 1'b0;
          unique case (grp_r)
            G_DET: begin
              if (acc_sum == '0) begin
                // singular: drop the whole update
                upd_nxt   = 1'b0;
                state_nxt = ST_DONE;
              end else begin
                det_neg_nxt = acc_sum[ACC_W-1];
                ud_nxt      = acc_sum[ACC_W-1] ? ACC_W'(-acc_sum) : ACC_W'(acc_sum);
                grp_nxt     = G_K00;
                acc_nxt     = '0;
                state_nxt   = ST_MUL;
              end
            end
            G_K00, G_K01, G_K10, G_K11: begin
              state_nxt = ST_DIV_INIT;
            end
            G_EST_X: begin
              est_nxt[0] = sat_q(acc_sum);
              grp_nxt    = G_EST_Y;
              acc_nxt    = acc_t'(est_r[1]);
              state_nxt  = ST_MUL;
            end
            G_EST_Y: begin
              est_nxt[1] = sat_q(acc_sum);
              state_nxt  = ST_MCONV;
            end
            G_P00: begin
              cov_nxt[0] = sat_q(acc_sum);
              grp_nxt    = G_P01;
              acc_nxt    = '0;
              state_nxt  = ST_MUL;
            end
            G_P01: begin
              cov_nxt[1] = sat_q(acc_sum);
              grp_nxt    = G_P10;
              acc_nxt    = '0;
              state_nxt  = ST_MUL;
            end
            G_P10: begin
              cov_nxt[2] = sat_q(acc_sum);
              grp_nxt    = G_P11;
              acc_nxt    = '0;
              state_nxt  = ST_MUL;
            end
            G_P11: begin
              cov_nxt[3] = sat_q(acc_sum);
              upd_nxt    = 1'b1;
              state_nxt  = ST_DONE;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_DIV_INIT: begin
        k_neg_nxt = acc_r[ACC_W-1] ^ det_neg_r;
        rem_nxt   = ACC_W'(num_hi);
        dvd_nxt   = num_w[QUO_W-1:0];
        cnt_nxt   = '0;
        if (num_hi >= NUM_W'(ud_r)) begin
          // quotient would not fit: force saturation
          quo_nxt   = '1;
          state_nxt = ST_DIV_END;
        end else begin
          quo_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (trial >= ud_r) begin
          rem_nxt = trial - ud_r;
          quo_nxt = {quo_r[QUO_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial;
          quo_nxt = {quo_r[QUO_W-2:0], 1'b0};
        end
        dvd_nxt = {dvd_r[QUO_W-2:0], 1'b0};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(QUO_W - 1)) begin
          state_nxt = ST_DIV_END;
        end
      end
      ST_DIV_END: begin
        state_nxt = ST_MUL;
        acc_nxt   = '0;
        unique case (grp_r)
          G_K00: begin
            k_nxt[0] = k_val;
            grp_nxt  = G_K01;
          end
          G_K01: begin
            k_nxt[1] = k_val;
            grp_nxt  = G_K10;
          end
          G_K10: begin
            k_nxt[2] = k_val;
            grp_nxt  = G_K11;
          end
          G_K11: begin
            k_nxt[3] = k_val;
            grp_nxt  = G_EST_X;
            acc_nxt  = acc_t'(est_r[0]);
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_MCONV: begin
        // turn the gain into I - K in place
        for (int i = 0; i < 4; i++) begin
          k_nxt[i] = sat_q(acc_t'((i == 0 || i == 3) ? Q_ONE : q_t'(0)) - acc_t'(k_r[i]));
        end
        grp_nxt   = G_P00;
        acc_nxt   = '0;
        state_nxt = ST_MUL;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {est_r[1], est_r[0]};
          out_user_nxt  = upd_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_r       <= G_DET;
      half_r      <= 1'b0;
      cnt_r       <= '0;
      upd_r       <= 1'b0;
      out_valid_r <= 1'b0;
      pvx_r       <= VAR_RESET;
      pvy_r       <= VAR_RESET;
      mvx_r       <= VAR_RESET;
      mvy_r       <= VAR_RESET;
      min_sat_r   <= MIN_SATS_RESET;
      est_r       <= '{default: '0};
      cov_r       <= '{default: '0};
    end else begin
      grp_r       <= grp_nxt;
      half_r      <= half_nxt;
      cnt_r       <= cnt_nxt;
      upd_r       <= upd_nxt;
      out_valid_r <= out_valid_nxt;
      est_r       <= est_nxt;
      cov_r       <= cov_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_PROC_VAR_X: pvx_r     <= cfg_wdata;
          REG_PROC_VAR_Y: pvy_r     <= cfg_wdata;
          REG_MEAS_VAR_X: mvx_r     <= cfg_wdata;
          REG_MEAS_VAR_Y: mvy_r     <= cfg_wdata;
          REG_MIN_SATS:   min_sat_r <= cfg_wdata[SAT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r        <= p_nxt;
    k_r        <= k_nxt;
    inn_r      <= inn_nxt;
    s0_r       <= s0_nxt;
    s3_r       <= s3_nxt;
    zx_r       <= zx_nxt;
    zy_r       <= zy_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    ud_r       <= ud_nxt;
    rem_r      <= rem_nxt;
    dvd_r      <= dvd_nxt;
    quo_r      <= quo_nxt;
    det_neg_r  <= det_neg_nxt;
    k_neg_r    <= k_neg_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while a fix is in work");

  a_est_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_ACC) |=> ($stable(est_r[0]) && $stable(est_r[1])))
    else $error("estimate changed outside a writeback");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cnt_r <= CNT_W'(QUO_W - 1)))
    else $error("divider ran past its last quotient bit");

  a_done_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && (!out_valid_r || out_tready)) |=>
      (out_tvalid && state_r == ST_IDLE))
    else $error("result word not loaded on completion");

endmodule

// ===== dv/kalman_position_filter_2d_unit_test.sv =====
// Self-checking bench for the 2-D position Kalman filter: predicts every result word.
module kalman_position_filter_2d_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import kpf2d_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int HOLD_CYCLES = 600;
  localparam int DRAIN_CYCLES = 250;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 166;

  typedef struct {
    q_t   est_x;
    q_t   est_y;
    logic updated;
  } fix_word_t;

  class fix_scoreboard;
    logic [DATA_W-1:0] proc_var_x, proc_var_y, meas_var_x, meas_var_y;
    logic [SAT_W-1:0]  min_sats;
    q_t                est[2];
    q_t                cov[4];
    fix_word_t         expected_words[$];
    int                mismatches;
    int                n_applied, n_low_sats, n_singular, n_checked;

    function new();
      proc_var_x = VAR_RESET;
      proc_var_y = VAR_RESET;
      meas_var_x = VAR_RESET;
      meas_var_y = VAR_RESET;
      min_sats   = MIN_SATS_RESET;
      est = '{default: '0};
      cov = '{default: '0};
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // scaled product, rounded half away from zero
    function longint mul_round(longint a, longint b);
      longint p;
      longint m;
      p = a * b;
      m = (p < 0) ? -p : p;
      m = (m + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      return (p < 0) ? -m : m;
    endfunction

    // (n << FRAC_BITS) / d, truncated toward zero, capped, then saturated
    function longint div_gain(longint n, longint d);
      longint unsigned un, ud, q, r, cap;
      bit neg;
      neg = (n < 0) != (d < 0);
      un = (n < 0) ? -n : n;
      ud = (d < 0) ? -d : d;
      cap = 64'd1 << 32;
      q = un / ud;
      r = un % ud;
      if (q > cap) q = cap;
      for (int i = 0; i < FRAC_BITS; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= ud) begin
          r = r - ud;
          q = q | 64'd1;
        end
        if (q > cap) q = cap;
      end
      return clamp32(neg ? -longint'(q) : longint'(q));
    endfunction

    function void set_reg(logic [CFG_AW-1:0] addr, logic [DATA_W-1:0] data);
      case (addr)
        REG_PROC_VAR_X: proc_var_x = data;
        REG_PROC_VAR_Y: proc_var_y = data;
        REG_MEAS_VAR_X: meas_var_x = data;
        REG_MEAS_VAR_Y: meas_var_y = data;
        REG_MIN_SATS:   min_sats = data[SAT_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void note_fix(q_t zx, q_t zy, logic [SAT_W-1:0] sats);
      longint p[4], s[4], adj[4], k[4], m[4], inn[2];
      longint det, id;
      fix_word_t w;
      w.updated = 1'b0;
      if (sats < min_sats) begin
        n_low_sats++;
      end else begin
        p[0] = clamp32(longint'(cov[0]) + longint'({32'b0, proc_var_x}));
        p[1] = longint'(cov[1]);
        p[2] = longint'(cov[2]);
        p[3] = clamp32(longint'(cov[3]) + longint'({32'b0, proc_var_y}));
        s[0] = clamp32(longint'({32'b0, meas_var_x}) + p[0]);
        s[1] = p[1];
        s[2] = p[2];
        s[3] = clamp32(longint'({32'b0, meas_var_y}) + p[3]);
        det = mul_round(s[0], s[3]) - mul_round(s[1], s[2]);
        if (det == 0) begin
          n_singular++;
        end else begin
          adj[0] = s[3];
          adj[1] = -s[1];
          adj[2] = -s[2];
          adj[3] = s[0];
          for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++)
              k[i*2+j] = div_gain(mul_round(p[i*2], adj[j]) +
                                  mul_round(p[i*2+1], adj[2+j]), det);
          inn[0] = clamp32(longint'(zx) - longint'(est[0]));
          inn[1] = clamp32(longint'(zy) - longint'(est[1]));
          for (int i = 0; i < 2; i++)
            est[i] = q_t'(clamp32(longint'(est[i]) + mul_round(k[i*2], inn[0]) +
                                  mul_round(k[i*2+1], inn[1])));
          for (int i = 0; i < 4; i++) begin
            id = (i == 0 || i == 3) ? (64'sd1 <<< FRAC_BITS) : 64'sd0;
            m[i] = clamp32(id - k[i]);
          end
          // covariance update reads the pre-update P held in p[]
          for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++)
              cov[i*2+j] = q_t'(clamp32(mul_round(m[i*2], p[j]) +
                                        mul_round(m[i*2+1], p[2+j])));
          w.updated = 1'b1;
          n_applied++;
        end
      end
      w.est_x = est[0];
      w.est_y = est[1];
      expected_words.push_back(w);
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_word(logic [OUT_W-1:0] data, logic user);
      fix_word_t w;
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("result word %h/%b with none expected", data, user));
        return;
      end
      w = expected_words.pop_front();
      n_checked++;
      if (q_t'(data[DATA_W-1:0]) !== w.est_x)
        report_mismatch($sformatf("word %0d est_x got %h want %h",
                                  n_checked, data[DATA_W-1:0], w.est_x));
      if (q_t'(data[2*DATA_W-1:DATA_W]) !== w.est_y)
        report_mismatch($sformatf("word %0d est_y got %h want %h",
                                  n_checked, data[2*DATA_W-1:DATA_W], w.est_y));
      if (user !== w.updated)
        report_mismatch($sformatf("word %0d updated got %b want %b",
                                  n_checked, user, w.updated));
    endtask
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CFG_AW-1:0]   cfg_addr;
  logic [DATA_W-1:0]   cfg_wdata;
  logic                in_tvalid;
  logic                in_tready;
  logic [IN_W-1:0]     in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_W-1:0]    out_tdata;
  logic                out_tuser;

  fix_scoreboard sb;
  int  send_idle_pct;
  int  recv_idle_pct;
  bit  hold_req;
  int  holds_done;
  int  fixes_sent;
  int  settings_used;
  int  cycle_count;

  kalman_position_filter_2d_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d words outstanding", cycle_count, sb.pending());
    $display("kalman_position_filter_2d_unit_test: FAIL");
    $finish;
  end

  // result side: random back-pressure, one long hold on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        holds_done++;
      end
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tdata, out_tuser);
  end

  // called at a falling edge; returns at a falling edge with tvalid left high
  task automatic send_fix(q_t x, q_t y, logic [SAT_W-1:0] sats);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_W - 2*DATA_W - SAT_W){1'b0}}, sats, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_fix(x, y, sats);
    fixes_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_regs(logic [DATA_W-1:0] pvx, logic [DATA_W-1:0] pvy,
                            logic [DATA_W-1:0] mvx, logic [DATA_W-1:0] mvy,
                            logic [SAT_W-1:0] ms);
    logic [CFG_AW-1:0] addrs[5];
    logic [DATA_W-1:0] vals[5];
    addrs = '{REG_PROC_VAR_X, REG_PROC_VAR_Y, REG_MEAS_VAR_X, REG_MEAS_VAR_Y, REG_MIN_SATS};
    vals  = '{pvx, pvy, mvx, mvy, {{(DATA_W - SAT_W){1'b0}}, ms}};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= addrs[i];
      cfg_wdata <= vals[i];
      sb.set_reg(addrs[i], vals[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [DATA_W-1:0] pick_var();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return $urandom;
      default: return $urandom_range(1, 32'h0010_0000);
    endcase
  endfunction

  // mostly a noisy walk around base, sometimes anywhere or at the rails
  function automatic q_t pick_pos(q_t base);
    longint v;
    case ($urandom_range(0, 19))
      0: return q_t'($urandom);
      1: return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
      default: begin
        v = longint'(base) + longint'($urandom_range(0, 32'h0010_0000)) - 64'sd524288;
        return q_t'(sb.clamp32(v));
      end
    endcase
  endfunction

  task automatic run_random_phase(int idx);
    q_t bx, by;
    logic [SAT_W-1:0] sats;
    case (idx)
      0: write_regs(VAR_RESET, VAR_RESET, VAR_RESET, VAR_RESET, MIN_SATS_RESET);
      1: write_regs('1, '1, '1, '1, '0);
      2: write_regs('0, '0, '0, '0, '0);
      3: write_regs(pick_var(), pick_var(), pick_var(), pick_var(), '1);
      default: write_regs(pick_var(), pick_var(), pick_var(), pick_var(),
                          $urandom_range(0, 9) == 0 ? 6'd63 : SAT_W'($urandom_range(0, 12)));
    endcase
    if (idx < 2) begin
      send_idle_pct = 36;
      recv_idle_pct = 57;
    end else if (idx < 5) begin
      send_idle_pct = 57;
      recv_idle_pct = 36;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    // let the block fill up and stall its input behind a blocked result
    if (idx == 1) hold_req = 1'b1;
    bx = $urandom_range(0, 3) == 0 ? q_t'($urandom) : q_t'($urandom_range(0, 32'h0100_0000));
    by = $urandom_range(0, 3) == 0 ? q_t'($urandom) : q_t'($urandom_range(0, 32'h0100_0000));
    for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
      if (idx == 4 && i == ITEMS_PER_PHASE / 2) drain();
      bx = q_t'(sb.clamp32(longint'(bx) + longint'($urandom_range(0, 4096)) - 64'sd2048));
      by = q_t'(sb.clamp32(longint'(by) + longint'($urandom_range(0, 4096)) - 64'sd2048));
      if ($urandom_range(0, 99) < 75) sats = SAT_W'($urandom_range(sb.min_sats, 63));
      else sats = SAT_W'($urandom_range(0, 63));
      send_fix(pick_pos(bx), pick_pos(by), sats);
    end
    drain();
  endtask

  initial begin
    sb = new();
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    send_idle_pct = 36;
    recv_idle_pct = 57;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: rails, bit patterns, satellite count around the threshold
    send_fix('0, '0, 6'd6);
    send_fix('0, '0, 6'd5);
    send_fix(Q_MAX, Q_MAX, 6'd63);
    send_fix(Q_MIN, Q_MIN, 6'd63);
    send_fix(Q_MAX, Q_MIN, 6'd7);
    send_fix(q_t'(-1), q_t'(1), 6'd0);
    send_fix(Q_ONE, -Q_ONE, 6'd6);
    send_fix(q_t'(32'h5555_5555), q_t'(32'hAAAA_AAAA), 6'd42);
    send_fix(q_t'(32'hAAAA_AAAA), q_t'(32'h5555_5555), 6'd21);
    send_fix(q_t'(32'h0003_8000), q_t'(32'hFFFC_8000), 6'd63);
    send_fix('0, '0, 6'd0);
    send_fix(Q_MAX, Q_MAX, 6'd5);
    drain();

    // zero noise: gain collapses to identity, then S turns singular
    write_regs('0, '0, '0, '0, '0);
    send_fix(Q_ONE, 2 * Q_ONE, 6'd0);
    send_fix(3 * Q_ONE, -4 * Q_ONE, 6'd0);
    send_fix('0, '0, 6'd0);
    send_fix(Q_MAX, Q_MIN, 6'd1);
    send_fix(q_t'(5), q_t'(5), 6'd63);
    drain();

    // variances at and above 2^31 saturate the sums
    write_regs('1, 32'h8000_0000, 32'h8000_0000, '1, '1);
    send_fix(Q_MIN, Q_MAX, 6'd63);
    send_fix(q_t'(123456), q_t'(-654321), 6'd62);
    send_fix(Q_MAX, Q_MIN, 6'd63);
    send_fix('0, '0, 6'd63);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) run_random_phase(p);

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d expected words never arrived", sb.pending()));
    $display("run: %0d fixes over %0d register settings, %0d long output holds",
             fixes_sent, settings_used, holds_done);
    $display("     %0d applied, %0d below satellite minimum, %0d singular, %0d mismatches",
             sb.n_applied, sb.n_low_sats, sb.n_singular, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("kalman_position_filter_2d_unit_test: PASS");
    end else begin
      $display("kalman_position_filter_2d_unit_test: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/kpf2d_pkg.sv
hdl/kalman_position_filter_2d_unit.sv
dv/kalman_position_filter_2d_unit_test.sv
